// File: hw/rtl/swpr_pkg.sv
// Shared types and fixed field widths for the sliding window peak rate unit.
`timescale 1ns / 1ps

package swpr_pkg;

  localparam int unsigned TIME_IN_W = 32;   // width of the event_time port
  localparam int unsigned WIN_W     = 17;   // width of the window register
  localparam int unsigned CNT_W     = 9;    // width of the count fields

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(600);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } swpr_state_t;

endpackage

// File: hw/rtl/swpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module swpr_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/sliding_window_peak_rate_unit.sv
// Top level of the sliding window peak rate unit.
`timescale 1ns / 1ps

// Sliding window peak rate unit. Takes event timestamps (seconds, in the low
// TIME_BITS bits of in_event_time) grouped into histories closed by
// in_last_item, keeps the timestamps still inside the window of
// cfg window_seconds in a ring RAM of RING_DEPTH entries, and returns one
// word per event: the count of entries in the window ending at this event,
// the running peak of the history, a sticky overflow flag and an echo of the
// last flag (the peak of that word is the history's answer). An entry
// expires when new minus old, read as a signed TIME_BITS value, is positive
// and above the window. A full ring forces its oldest entry out. A window of
// zero reports zero counts. After a last word the ring, peak and flag reset.
// Flow: an item first scans the ring for entries to expire, if the ring
// holds any, then commits, and the commit waits while a previous result
// is held by out_stall; the ring is scanned from its tail one entry per
// cycle through the single read port of the RAM, whose read is registered,
// and the write of the new timestamp plus the result update share the
// commit cycle. Only one item is in flight; the result sits in an output
// register, so a new word is accepted while the previous result waits on
// out_stall. No clearing pass is needed after reset. The window register
// is to be written by cfg_wr_en only while the unit is idle; the block
// itself does not enforce this.

module sliding_window_peak_rate_unit
  import swpr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_IN_W-1:0] in_event_time,
  input  logic                 in_last_item,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     out_window_count,
  output logic [CNT_W-1:0]     out_peak_count,
  output logic                 out_overflowed,
  output logic                 out_history_done,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [WIN_W-1:0]     cfg_wr_data
);

  localparam int unsigned AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int unsigned OW    = (OCC_W > CNT_W) ? OCC_W : CNT_W;
  localparam int unsigned EXT_W = TIME_IN_W + 64;

  localparam logic [AW-1:0]    LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(RING_DEPTH);
  localparam logic [OCC_W-1:0] ONE_OCC   = OCC_W'(1);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : AW'(idx + 1'b1);
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [OCC_W-1:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return w[CNT_W-1:0];
  endfunction

  // state
  swpr_state_t          st_r, st_nxt;
  logic [WIN_W-1:0]     win_r;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [OCC_W-1:0]     peak_r, peak_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 last_r, last_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0]     out_peak_r, out_peak_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic                 out_done_r, out_done_nxt;

  // RAM port
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic                 wr_en;

  // scan and commit
  logic [EXT_W-1:0]     in_time_ext;
  logic [TIME_BITS-1:0] diff;
  logic                 expired;
  logic                 out_free;
  logic                 commit;
  logic [OCC_W-1:0]     base_occ;
  logic [AW-1:0]        base_tail;
  logic                 full_c;
  logic [OCC_W-1:0]     occ_c;
  logic                 win_zero;

  assign in_time_ext = EXT_W'(in_event_time);
  assign diff        = TIME_BITS'(time_r - rd_data);
  // positive distance only: a timestamp going backwards expires nothing
  assign expired     = !diff[TIME_BITS-1] && (CMP_W'(diff) > CMP_W'(win_r));
  assign out_free    = !out_valid_r || !out_stall;
  assign win_zero    = (win_r == '0);

  swpr_ram #(
    .DATA_W (TIME_BITS),
    .DEPTH  (RING_DEPTH),
    .ADDR_W (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (time_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    st_nxt        = st_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    peak_nxt      = peak_r;
    ovf_nxt       = ovf_r;
    time_nxt      = time_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_peak_nxt  = out_peak_r;
    out_ovf_nxt   = out_ovf_r;
    out_done_nxt  = out_done_r;
    in_stall      = 1'b1;
    rd_en         = 1'b0;
    rd_addr       = tail_r;
    wr_en         = 1'b0;
    commit        = 1'b0;
    base_occ      = occ_r;
    base_tail     = tail_r;
    full_c        = 1'b0;
    occ_c         = occ_r;

    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          time_nxt = in_time_ext[TIME_BITS-1:0];
          last_nxt = in_last_item;
          if (occ_r != '0) begin
            // fetch the oldest entry for the expiry scan
            rd_en  = 1'b1;
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        // rd_data holds the entry at tail_r
        if (expired) begin
          base_occ  = OCC_W'(occ_r - 1'b1);
          base_tail = slot_inc(tail_r);
        end
        if (expired && (occ_r != ONE_OCC)) begin
          tail_nxt = slot_inc(tail_r);
          occ_nxt  = OCC_W'(occ_r - 1'b1);
          rd_en    = 1'b1;
          rd_addr  = slot_inc(tail_r);
        end else if (out_free) begin
          commit = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (commit) begin
      // full ring: drop the oldest entry to make room
      full_c   = (base_occ == FULL_OCC);
      occ_c    = full_c ? base_occ : OCC_W'(base_occ + 1'b1);
      tail_nxt = full_c ? slot_inc(base_tail) : base_tail;
      occ_nxt  = occ_c;
      wr_en    = 1'b1;
      head_nxt = slot_inc(head_r);
      ovf_nxt  = ovf_r || (occ_c == FULL_OCC);
      if (!win_zero && (occ_c > peak_r)) begin
        peak_nxt = occ_c;
      end
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = win_zero ? '0 : to_cnt(occ_c);
      out_peak_nxt  = win_zero ? '0 : to_cnt(peak_nxt);
      out_ovf_nxt   = ovf_nxt;
      out_done_nxt  = last_r;
      if (last_r) begin
        // history closed: start the next one empty
        head_nxt = '0;
        tail_nxt = '0;
        occ_nxt  = '0;
        peak_nxt = '0;
        ovf_nxt  = 1'b0;
      end
      st_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      win_r       <= WINDOW_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      peak_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      peak_r      <= peak_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    time_r     <= time_nxt;
    last_r     <= last_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_peak_r <= out_peak_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_window_count = out_cnt_r;
  assign out_peak_count   = out_peak_r;
  assign out_overflowed   = out_ovf_r;
  assign out_history_done = out_done_r;

  // ring never holds more than its depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_OCC)
    else $error("ring occupancy above depth");

  // a new result only ever comes from a commit cycle
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |->
      ($past(st_r) == ST_SCAN || $past(st_r) == ST_COMMIT))
    else $error("result appeared without a commit");

  // closing a history leaves the ring empty
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && last_r) |=> (occ_r == '0 && peak_r == '0 && !ovf_r))
    else $error("history state not cleared after last word");

  // the RAM is never read and written in the same cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("ring read and write collide");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the sliding window peak rate unit: driver, monitor, window predictor.

module testbench;
  import swpr_pkg::*;

  // Ring size and timestamp width match the block's defaults.
  localparam int unsigned RING_DEPTH  = 256;
  localparam int unsigned IDLE_MAX    = 11;    // per-word idle draw, both sides
  localparam int unsigned SETTLE_CYC  = 4;     // quiet cycles before a window write
  localparam int unsigned HOLD_AT     = 400;   // words sent before the long receiver hold
  localparam int unsigned HOLD_CYC    = 150;   // length of that hold
  localparam int unsigned QUIET_LIMIT = 4000;  // watchdog: cycles without any handshake
  localparam int unsigned ITEM_GOAL   = 1750;
  localparam int unsigned PHASES      = 8;

  // What the sender does next: offer an event word, rewrite the window,
  // or pause until every outstanding result has come back.
  typedef enum logic [1:0] {
    ARR_EVENT,
    ARR_WINDOW,
    ARR_DRAIN
  } arrival_kind_t;

  typedef struct {
    arrival_kind_t        kind;
    logic [TIME_IN_W-1:0] ts;
    logic                 last;
    logic [WIN_W-1:0]     win;
    int unsigned          gap;
  } arrival_t;

  // One result word as the block should return it.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] peak;
    logic             ovf;
    logic             done;
  } tally_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_IN_W-1:0] in_event_time = '0;
  logic                 in_last_item = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CNT_W-1:0]     out_window_count;
  logic [CNT_W-1:0]     out_peak_count;
  logic                 out_overflowed;
  logic                 out_history_done;
  logic                 cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]     cfg_wr_data = '0;

  sliding_window_peak_rate_unit #(
    .RING_DEPTH(RING_DEPTH),
    .TIME_BITS (TIME_IN_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_event_time   (in_event_time),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_count(out_window_count),
    .out_peak_count  (out_peak_count),
    .out_overflowed  (out_overflowed),
    .out_history_done(out_history_done),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // ---------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------
  arrival_t    arrivals[$];          // everything the sender still has to do
  tally_t      expected_tallies[$];  // results owed by the block, oldest first
  int unsigned events_planned = 0;
  int unsigned words_sent     = 0;
  int unsigned words_seen     = 0;
  int unsigned mismatches     = 0;

  // ---------------------------------------------------------------------
  // Window predictor: its own copy of the ring, the history state and the
  // window register. Called once per accepted event word.
  // ---------------------------------------------------------------------
  logic [TIME_IN_W-1:0] ring_ts[RING_DEPTH];
  int unsigned          ring_head = 0;
  int unsigned          ring_tail = 0;
  int unsigned          ring_fill = 0;
  int unsigned          peak_seen = 0;
  logic                 ovf_seen  = 1'b0;
  logic [WIN_W-1:0]     win_len   = WINDOW_RESET;

  function automatic tally_t tally_event(input logic [TIME_IN_W-1:0] ts, input logic last);
    tally_t               r;
    logic [TIME_IN_W-1:0] delta;
    int unsigned          cnt;
    bit                   scanning;
    scanning = 1'b1;
    // Drop stale entries oldest first. The distance wraps and is read as
    // signed, so a step backwards (or a half-range jump) expires nothing.
    while (ring_fill > 0 && scanning) begin
      delta = ts - ring_ts[ring_tail];
      if (!delta[TIME_IN_W-1] && delta > TIME_IN_W'(win_len)) begin
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        ring_fill--;
      end else begin
        scanning = 1'b0;
      end
    end
    // Ring full: evict the oldest to make room.
    if (ring_fill >= RING_DEPTH) begin
      ring_tail = (ring_tail + 1) % RING_DEPTH;
      ring_fill = RING_DEPTH - 1;
    end
    ring_ts[ring_head] = ts;
    ring_head = (ring_head + 1) % RING_DEPTH;
    ring_fill++;
    if (ring_fill >= RING_DEPTH) ovf_seen = 1'b1;
    // Zero window reports zeros and leaves the peak alone.
    if (win_len == '0) begin
      cnt    = 0;
      r.peak = '0;
    end else begin
      cnt = ring_fill;
      if (cnt > peak_seen) peak_seen = cnt;
      r.peak = CNT_W'(peak_seen);
    end
    r.count = CNT_W'(cnt);
    r.ovf   = ovf_seen;
    r.done  = last;
    // Close of history: fresh ring, peak and flag; the window stays.
    if (last) begin
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      peak_seen = 0;
      ovf_seen  = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender plan helpers
  // ---------------------------------------------------------------------
  function automatic void add_event(input logic [TIME_IN_W-1:0] ts, input logic last,
                                    input int unsigned gap);
    arrival_t a;
    a.kind = ARR_EVENT;
    a.ts   = ts;
    a.last = last;
    a.win  = '0;
    a.gap  = gap;
    arrivals.push_back(a);
    events_planned++;
  endfunction

  function automatic void add_window(input int unsigned w);
    arrival_t a;
    a.kind = ARR_WINDOW;
    a.ts   = '0;
    a.last = 1'b0;
    a.win  = WIN_W'(w);
    a.gap  = 0;
    arrivals.push_back(a);
  endfunction

  function automatic void add_drain();
    arrival_t a;
    a.kind = ARR_DRAIN;
    a.ts   = '0;
    a.last = 1'b0;
    a.win  = '0;
    a.gap  = 0;
    arrivals.push_back(a);
  endfunction

  task automatic report_miss(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Driver. Works through the plan one entry at a time. Each event word
  // waits out its own idle count, then valid goes up and stays up with a
  // frozen payload until the block takes it. Window writes only happen
  // with nothing owed and a few quiet cycles behind us. Next-state values
  // are built in locals so each output sees a single NBA per edge.
  // ---------------------------------------------------------------------
  int unsigned gap_left    = 0;
  bit          gap_armed   = 1'b0;
  int unsigned settle_left = 0;

  always @(posedge clk) begin
    logic nxt_valid;
    logic nxt_cfg;
    nxt_valid = in_valid;
    nxt_cfg   = 1'b0;
    if (!rst_n) begin
      nxt_valid   = 1'b0;
      gap_armed   = 1'b0;
      settle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_tallies.push_back(tally_event(in_event_time, in_last_item));
        words_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && arrivals.size() > 0) begin
        case (arrivals[0].kind)
          ARR_EVENT: begin
            if (!gap_armed) begin
              gap_left  = arrivals[0].gap;
              gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              in_event_time <= arrivals[0].ts;
              in_last_item  <= arrivals[0].last;
              nxt_valid = 1'b1;
              gap_armed = 1'b0;
              void'(arrivals.pop_front());
            end
          end
          ARR_WINDOW: begin
            if (expected_tallies.size() != 0) begin
              settle_left = 0;
            end else if (settle_left < SETTLE_CYC) begin
              settle_left++;
            end else begin
              cfg_wr_data <= arrivals[0].win;
              nxt_cfg     = 1'b1;
              win_len     = arrivals[0].win;
              settle_left = 0;
              void'(arrivals.pop_front());
            end
          end
          ARR_DRAIN: begin
            if (expected_tallies.size() == 0) void'(arrivals.pop_front());
          end
          default: void'(arrivals.pop_front());
        endcase
      end
    end
    in_valid  <= nxt_valid;
    cfg_wr_en <= nxt_cfg;
  end

  // ---------------------------------------------------------------------
  // Monitor. Stalls for a random idle draw after each word, except in every
  // third block of 100 words where it never stalls. Once HOLD_AT words have
  // gone in, it holds off once for the long hold so the block backs up into
  // in_stall while the driver keeps offering.
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_taken = 1'b0;

  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (!hold_taken && words_sent >= HOLD_AT) begin
        hold_left  = HOLD_CYC;
        hold_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.count = out_window_count;
        got.peak  = out_peak_count;
        got.ovf   = out_overflowed;
        got.done  = out_history_done;
        words_seen++;
        if (expected_tallies.size() == 0) begin
          report_miss($sformatf("unexpected word: count=%0d peak=%0d ovf=%0b done=%0b",
                                got.count, got.peak, got.ovf, got.done));
        end else begin
          want = expected_tallies.pop_front();
          if (got.count !== want.count || got.peak !== want.peak ||
              got.ovf !== want.ovf || got.done !== want.done) begin
            report_miss({
              $sformatf("word %0d: exp count=%0d peak=%0d ovf=%0b done=%0b, ",
                        words_seen, want.count, want.peak, want.ovf, want.done),
              $sformatf("got count=%0d peak=%0d ovf=%0b done=%0b",
                        got.count, got.peak, got.ovf, got.done)});
          end
        end
        stall_left = ((words_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any stretch this long with no handshake on either side is a
  // hang (covers the worst 256-entry expiry scan and the long hold).
  // ---------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned          win_plan[PHASES];
    int unsigned          wlen;
    int unsigned          phase_items;
    int unsigned          hist_len;
    int unsigned          step_max;
    int unsigned          pick;
    logic [TIME_IN_W-1:0] ts;
    bit                   burst;
    bit                   clean;
    bit                   force_long;

    // Directed part, window at its reset value of 600 first.
    add_event(32'd0, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'd0, 1'b0, $urandom_range(0, IDLE_MAX));           // equal timestamps
    add_event(32'd600, 1'b0, $urandom_range(0, IDLE_MAX));         // exactly on the edge
    add_event(32'd601, 1'b0, $urandom_range(0, IDLE_MAX));         // one past: both zeros go
    add_event(32'd300, 1'b0, $urandom_range(0, IDLE_MAX));         // time runs backwards
    add_event(32'hFFFF_FFFF, 1'b1, $urandom_range(0, IDLE_MAX));   // top of range, closes
    add_event(32'hFFFF_FF00, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'h0000_0100, 1'b0, $urandom_range(0, IDLE_MAX));   // wraps through zero
    add_event(32'h0000_0400, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'h8000_0400, 1'b1, $urandom_range(0, IDLE_MAX));   // half range reads negative
    add_drain();
    add_window(1);
    add_event(32'd5, 1'b0, 0);
    add_event(32'd6, 1'b0, 0);
    add_event(32'd8, 1'b0, 0);
    add_event(32'd8, 1'b1, 0);
    add_window(0);                                                 // counts forced to zero
    add_event(32'd10, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'd10, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'd11, 1'b1, $urandom_range(0, IDLE_MAX));
    add_window(131071);                                            // all ones, above range
    add_event(32'd0, 1'b0, 0);
    add_event(32'd131071, 1'b0, 0);
    add_event(32'd131072, 1'b1, 0);
    add_window(86400);
    add_event(32'd1000, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'd87400, 1'b0, $urandom_range(0, IDLE_MAX));
    add_event(32'd87401, 1'b1, $urandom_range(0, IDLE_MAX));

    // Random part: one window setting per phase, histories of random length.
    // Most steps are small forward moves; some jump past the window, some
    // land anywhere, a few go backwards. The third phase opens with a clean
    // dense history long enough to fill the ring.
    win_plan = '{600, 1, 86400, 0, 131071, $urandom_range(2, 86400),
                 $urandom_range(0, 131071), 60};
    for (int ph = 0; ph < PHASES; ph++) begin
      wlen = win_plan[ph];
      add_window(wlen);
      phase_items = 0;
      force_long  = (ph == 2);
      while (phase_items < ITEM_GOAL / PHASES) begin
        pick = $urandom_range(0, 99);
        if (force_long)     hist_len = 270;
        else if (pick < 75) hist_len = $urandom_range(1, 24);
        else if (pick < 95) hist_len = $urandom_range(25, 120);
        else                hist_len = $urandom_range(257, 300);
        // keep the phase close to its share of the item budget
        if (!force_long && hist_len > ITEM_GOAL / PHASES - phase_items)
          hist_len = ITEM_GOAL / PHASES - phase_items;
        clean    = force_long;
        step_max = (force_long || $urandom_range(0, 3) == 0) ? 1 : wlen / 16 + 1;
        burst    = ($urandom_range(0, 3) == 0);
        ts       = $urandom();
        for (int k = 0; k < hist_len; k++) begin
          if (k > 0) begin
            pick = clean ? 0 : $urandom_range(0, 99);
            if (pick < 80)      ts = ts + $urandom_range(0, step_max);
            else if (pick < 90) ts = ts + wlen + $urandom_range(1, wlen + 1);
            else if (pick < 95) ts = $urandom();
            else                ts = ts - $urandom_range(1, wlen + 1);
          end
          add_event(ts, (k == hist_len - 1), burst ? 0 : $urandom_range(0, IDLE_MAX));
        end
        phase_items += hist_len;
        force_long = 1'b0;
        if ($urandom_range(0, 14) == 0) add_drain();
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Everything sent and answered, then a short tail for stray words.
    while (words_sent < events_planned || expected_tallies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_tallies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/swpr_pkg.sv
hw/rtl/swpr_ram.sv
hw/rtl/sliding_window_peak_rate_unit.sv
bench/testbench.sv
